@@ sv/sbph_pkg.sv @@
// shared types and constants for the spectrum bar peak-hold block
// no dependencies; imported by the top level and by sbph_mag_pipe
package sbph_pkg;

    localparam int BIN_W     = 7;
    localparam int DATA_W    = 16;
    localparam int SQ_W      = 31;
    localparam int RAD_W     = 34;
    localparam int MAG_W     = 17;
    localparam int REM_W     = 18;
    localparam int DIV_W     = 8;
    localparam int BAR_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int SQ_STEPS  = 17;
    localparam int DIV_STEPS = 6;

    localparam logic [DIV_W-1:0] LEVEL_DIVISOR_RST = 8'd4;
    localparam logic [BAR_W-1:0] BAR_LIMIT_RST     = 6'd63;

    typedef enum logic
    {
        OP_BIN   = 1'b0,
        OP_CLEAR = 1'b1
    } sbph_op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_LEVEL_DIVISOR = 1'b0,
        REG_BAR_LIMIT     = 1'b1
    } sbph_reg_t;

    typedef struct packed
    {
        logic             valid;
        sbph_op_t         op;
        logic [BIN_W-1:0] bin;
    } sbph_ctl_t;

endpackage

@@ sv/spectrum_bar_peak_hold_top.sv @@
// top level of the spectrum bar peak-hold block
// depends on sbph_pkg, sbph_mag_pipe and sbph_ram
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------
//   item     | item_valid / item_ready    | opcode, bin_index, real_part, imag_part
//   result   | result_valid / result_ready| bin_out, magnitude, bar_height,
//            |                            | peak_level, show_peak
//   cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// one item per cycle while item_ready is high; result_valid rises once the item has
// passed squares, radicand, 17 root stages, 6 divide stages, peak update and output
// after reset the peak ram is zeroed one entry per cycle, with item_ready low until
// every entry is cleared; a clear item stalls the pipeline for a sweep of its own
// a stalled result is held in a skid register; item_ready then drops for
// as long as the skid register is full
module spectrum_bar_peak_hold_top #(
    parameter int BIN_COUNT = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        opcode,
    input  logic [6:0]  bin_index,
    input  logic signed [15:0] real_part,
    input  logic signed [15:0] imag_part,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [6:0]  bin_out,
    output logic [16:0] magnitude,
    output logic [5:0]  bar_height,
    output logic [5:0]  peak_level,
    output logic        show_peak,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import sbph_pkg::*;

    localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int BW = AW + BIN_W;

    typedef struct packed
    {
        logic [BIN_W-1:0] bin;
        logic [MAG_W-1:0] mag;
        logic [BAR_W-1:0] bar;
        logic [BAR_W-1:0] peak;
        logic             show;
    } res_t;

    // configuration
    logic [DIV_W-1:0] level_divisor_reg;
    logic [BAR_W-1:0] bar_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_divisor_reg <= LEVEL_DIVISOR_RST;
            bar_limit_reg     <= BAR_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (sbph_reg_t'(cfg_index))
                REG_LEVEL_DIVISOR: level_divisor_reg <= cfg_data;
                REG_BAR_LIMIT:     bar_limit_reg     <= cfg_data[BAR_W-1:0];
                default:           ;
            endcase
        end
    end

    // pipeline control
    logic      adv;
    logic      sweep_reg;
    logic      skid_valid_reg;
    sbph_ctl_t in_ctl;
    sbph_ctl_t p_ctl;
    logic [MAG_W-1:0] p_mag;
    logic [BAR_W-1:0] p_bar;

    assign adv        = !skid_valid_reg && !sweep_reg;
    assign item_ready = adv;

    always_comb
    begin
        in_ctl.valid = item_valid;
        in_ctl.op    = sbph_op_t'(opcode);
        in_ctl.bin   = bin_index;
    end

    sbph_mag_pipe u_mag (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (adv),
        .in_ctl        (in_ctl),
        .re            (real_part),
        .im            (imag_part),
        .level_divisor (level_divisor_reg),
        .bar_limit     (bar_limit_reg),
        .out_ctl       (p_ctl),
        .out_mag       (p_mag),
        .out_bar       (p_bar)
    );

    // peak store read, issued as the item enters the update stage
    logic [BW-1:0]    p_bin_wide;
    logic [AW-1:0]    rd_addr;
    logic [BAR_W-1:0] ram_rd;

    assign p_bin_wide = BW'(p_ctl.bin);
    assign rd_addr    = p_bin_wide[AW-1:0];

    // update stage
    sbph_ctl_t        r_ctl_reg;
    logic [MAG_W-1:0] r_mag_reg;
    logic [BAR_W-1:0] r_bar_reg;
    logic [BW-1:0]    r_bin_wide;
    logic [AW-1:0]    r_addr;
    logic             r_in_range;
    logic             fwd_valid_reg;
    logic [AW-1:0]    fwd_addr_reg;
    logic [BAR_W-1:0] fwd_data_reg;
    logic [BAR_W-1:0] peak;
    logic             show;
    logic [BAR_W-1:0] peak_new;
    logic             item_wr;
    res_t             r_res;
    logic [AW-1:0]    sweep_cnt_reg;
    logic             sweep_done;
    logic             clear_enter;
    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [BAR_W-1:0] ram_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_ctl_reg <= '0;
        end
        else if (adv)
        begin
            r_ctl_reg <= p_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_mag_reg <= p_mag;
            r_bar_reg <= p_bar;
        end
    end

    assign r_bin_wide = BW'(r_ctl_reg.bin);
    assign r_addr     = r_bin_wide[AW-1:0];
    assign r_in_range = (r_bin_wide < BW'(BIN_COUNT));

    always_comb
    begin
        if (!r_in_range)
        begin
            peak = '0;
        end
        else if (fwd_valid_reg && (fwd_addr_reg == r_addr))
        begin
            peak = fwd_data_reg;
        end
        else
        begin
            peak = ram_rd;
        end
        show = !(r_bar_reg > peak);
        if (!show)
        begin
            peak_new = r_bar_reg;
        end
        else if (peak != '0)
        begin
            peak_new = peak - BAR_W'(1);
        end
        else
        begin
            peak_new = '0;
        end
    end

    assign item_wr = adv && r_ctl_reg.valid && (r_ctl_reg.op == OP_BIN) && r_in_range;

    always_comb
    begin
        r_res.bin = r_ctl_reg.bin;
        if (r_ctl_reg.op == OP_CLEAR)
        begin
            r_res.mag  = '0;
            r_res.bar  = '0;
            r_res.peak = '0;
            r_res.show = 1'b0;
        end
        else
        begin
            r_res.mag  = r_mag_reg;
            r_res.bar  = r_bar_reg;
            r_res.peak = peak;
            r_res.show = show;
        end
    end

    // clearing sweep: after reset, and when a clear enters the update stage
    assign sweep_done  = (sweep_cnt_reg == AW'(BIN_COUNT - 1));
    assign clear_enter = adv && p_ctl.valid && (p_ctl.op == OP_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
        end
        else if (sweep_reg)
        begin
            if (sweep_done)
            begin
                sweep_reg <= 1'b0;
            end
            sweep_cnt_reg <= sweep_cnt_reg + AW'(1);
        end
        else if (clear_enter)
        begin
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
        end
    end

    // last write, forwarded to a read that overlapped it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (sweep_reg)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (item_wr)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_wr)
        begin
            fwd_addr_reg <= r_addr;
            fwd_data_reg <= peak_new;
        end
    end

    assign ram_wr_en   = sweep_reg || item_wr;
    assign ram_wr_addr = sweep_reg ? sweep_cnt_reg : r_addr;
    assign ram_wr_data = sweep_reg ? '0 : peak_new;

    sbph_ram #(
        .WIDTH (BAR_W),
        .DEPTH (BIN_COUNT)
    ) u_peak_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (adv),
        .rd_addr (rd_addr),
        .rd_data (ram_rd)
    );

    // output register and skid register
    logic result_valid_reg;
    res_t out_reg;
    res_t skid_reg;
    logic push;
    logic pop;

    assign push = adv && r_ctl_reg.valid;
    assign pop  = result_valid_reg && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (!result_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                result_valid_reg <= 1'b1;
                skid_valid_reg   <= 1'b0;
            end
            else
            begin
                result_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!result_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= r_res;
            end
        end
        else if (push)
        begin
            skid_reg <= r_res;
        end
    end

    assign result_valid = result_valid_reg;
    assign bin_out      = out_reg.bin;
    assign magnitude    = out_reg.mag;
    assign bar_height   = out_reg.bar;
    assign peak_level   = out_reg.peak;
    assign show_peak    = out_reg.show;

    // checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid register full while output register empty");

    a_sweep_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sweep_reg) |-> (r_ctl_reg.valid && (r_ctl_reg.op == OP_CLEAR)))
        else $error("clearing sweep started without a clear transaction");

    a_no_item_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        item_wr |-> (!sweep_reg && r_in_range))
        else $error("peak write collides with clearing sweep");

endmodule

@@ sv/sbph_ram.sv @@
// generic single-write, single-read synchronous ram with registered read
// no dependencies; holds the per-bin peak levels
module sbph_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/sbph_mag_pipe.sv @@
// magnitude pipeline: squares, digit-by-digit square root, saturating divide
// depends on sbph_pkg
module sbph_mag_pipe (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  sbph_pkg::sbph_ctl_t          in_ctl,
    input  logic signed [15:0]           re,
    input  logic signed [15:0]           im,
    input  logic [7:0]                   level_divisor,
    input  logic [5:0]                   bar_limit,
    output sbph_pkg::sbph_ctl_t          out_ctl,
    output logic [16:0]                  out_mag,
    output logic [5:0]                   out_bar
);
    import sbph_pkg::*;

    typedef struct packed
    {
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] root;
        logic [RAD_W-1:0] rad;
    } sq_t;

    typedef struct packed
    {
        logic [MAG_W-1:0] rem;
        logic [BAR_W-1:0] quo;
        logic             sat;
    } dv_t;

    function automatic sq_t sqrt_step(input sq_t s);
        logic [REM_W+1:0] acc;
        logic [REM_W+1:0] trial;
        sq_t              r;
        acc   = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial = (REM_W+2)'({s.root, 2'b01});
        r.rad = {s.rad[RAD_W-3:0], 2'b00};
        if (acc >= trial)
        begin
            r.rem  = REM_W'(acc - trial);
            r.root = {s.root[MAG_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = acc[REM_W-1:0];
            r.root = {s.root[MAG_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic dv_t div_step(input dv_t s, input logic [MAG_W-1:0] dd);
        dv_t r;
        r.sat = s.sat;
        if (s.rem >= dd)
        begin
            r.rem = s.rem - dd;
            r.quo = {s.quo[BAR_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = s.rem;
            r.quo = {s.quo[BAR_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // squares
    sbph_ctl_t         a_ctl_reg;
    logic [SQ_W-1:0]   a_re2_reg;
    logic [SQ_W-1:0]   a_im2_reg;
    logic signed [31:0] re_sq;
    logic signed [31:0] im_sq;

    assign re_sq = 32'(re) * 32'(re);
    assign im_sq = 32'(im) * 32'(im);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
        end
        else if (en)
        begin
            a_ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_re2_reg <= re_sq[SQ_W-1:0];
            a_im2_reg <= im_sq[SQ_W-1:0];
        end
    end

    // radicand, quadrupled for non-dc bins
    sbph_ctl_t       sq_ctl_reg [SQ_STEPS+1];
    sq_t             sq_reg     [SQ_STEPS+1];
    logic [SQ_W:0]   sum;
    sq_t             sq_first;

    assign sum = {1'b0, a_re2_reg} + {1'b0, a_im2_reg};

    always_comb
    begin
        sq_first.rem  = '0;
        sq_first.root = '0;
        if (a_ctl_reg.bin == '0)
        begin
            sq_first.rad = {2'b00, sum};
        end
        else
        begin
            sq_first.rad = {sum, 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_ctl_reg[0] <= '0;
        end
        else if (en)
        begin
            sq_ctl_reg[0] <= a_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0] <= sq_first;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_ctl_reg[k+1] <= '0;
            end
            else if (en)
            begin
                sq_ctl_reg[k+1] <= sq_ctl_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[k+1] <= sqrt_step(sq_reg[k]);
            end
        end
    end

    // one quotient bit per stage, overflow past the bar range saturates
    logic [DIV_W-1:0] div_eff;
    sbph_ctl_t        dv_ctl_reg [DIV_STEPS];
    dv_t              dv_reg     [DIV_STEPS];
    logic [MAG_W-1:0] dv_mag_reg [DIV_STEPS];
    dv_t              dv_first;

    assign div_eff = (level_divisor == '0) ? DIV_W'(1) : level_divisor;

    always_comb
    begin
        dv_first.rem = sq_reg[SQ_STEPS].root;
        dv_first.quo = '0;
        dv_first.sat = (sq_reg[SQ_STEPS].root >= MAG_W'({div_eff, {BAR_W{1'b0}}}));
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int SH = DIV_STEPS - 1 - j;
        sbph_ctl_t        ctl_src;
        dv_t              dv_src;
        logic [MAG_W-1:0] mag_src;
        logic [MAG_W-1:0] dd;

        if (j == 0)
        begin : g_head
            assign ctl_src = sq_ctl_reg[SQ_STEPS];
            assign dv_src  = dv_first;
            assign mag_src = sq_reg[SQ_STEPS].root;
        end
        else
        begin : g_body
            assign ctl_src = dv_ctl_reg[j-1];
            assign dv_src  = dv_reg[j-1];
            assign mag_src = dv_mag_reg[j-1];
        end

        assign dd = MAG_W'(div_eff) << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_ctl_reg[j] <= '0;
            end
            else if (en)
            begin
                dv_ctl_reg[j] <= ctl_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[j]     <= div_step(dv_src, dd);
                dv_mag_reg[j] <= mag_src;
            end
        end
    end

    assign out_ctl = dv_ctl_reg[DIV_STEPS-1];
    assign out_mag = dv_mag_reg[DIV_STEPS-1];

    always_comb
    begin
        if (dv_reg[DIV_STEPS-1].sat || (dv_reg[DIV_STEPS-1].quo > bar_limit))
        begin
            out_bar = bar_limit;
        end
        else
        begin
            out_bar = dv_reg[DIV_STEPS-1].quo;
        end
    end

endmodule
